// File: design/mf3_pkg.sv
`default_nettype none

package mf3_pkg;

  localparam int MF3_MAX_WIDTH = 256;

  localparam int PIX_W  = 8;
  localparam int ROW_W  = 12;
  localparam int OCOL_W = 8;
  localparam int WCFG_W = 9;
  localparam int HCFG_W = 12;
  localparam int CIDX_W = 2;

  localparam logic [CIDX_W-1:0] CFG_IDX_WIDTH  = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_IDX_HEIGHT = 2'd1;

  typedef logic [PIX_W-1:0] pix_t;
  // One window column: [0] two rows up, [1] previous row, [2] current row.
  typedef pix_t [2:0] col3_t;
  typedef pix_t [8:0] pix9_t;

  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [OCOL_W-1:0] col;
    logic              last;
  } res_tag_t;

endpackage

`default_nettype wire

// File: design/mf3_ram.sv
`default_nettype none

module mf3_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// File: design/mf3_col_cell.sv
`default_nettype none

module mf3_col_cell import mf3_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  shift_en,
  input  wire logic  fill,
  input  wire col3_t new_col,
  input  wire col3_t next_col,
  output col3_t      col_q
);

  col3_t col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else if (shift_en) begin
      col_r <= fill ? new_col : next_col;
    end
  end

  assign col_q = col_r;

endmodule

`default_nettype wire

// File: design/mf3_median9.sv
`default_nettype none

module mf3_median9 import mf3_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire pix9_t    in_pix,
  input  wire res_tag_t in_tag,
  output logic          out_valid,
  input  wire logic     out_ready,
  output pix_t          out_med,
  output res_tag_t      out_tag
);

  function automatic pix9_t cas(input pix9_t p, input logic [3:0] a, input logic [3:0] b);
    pix9_t q;
    q = p;
    if (p[a] > p[b]) begin
      q[a] = p[b];
      q[b] = p[a];
    end
    return q;
  endfunction

  logic     v1_r, v2_r, v3_r;
  logic     rdy1, rdy2, rdy3;
  pix9_t    p1_r, p2_r;
  pix9_t    s1_nxt, s2_nxt, s3_nxt;
  pix_t     med_r;
  res_tag_t t1_r, t2_r, t3_r;

  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_comb begin
    s1_nxt = in_pix;
    s1_nxt = cas(s1_nxt, 4'd1, 4'd2);
    s1_nxt = cas(s1_nxt, 4'd4, 4'd5);
    s1_nxt = cas(s1_nxt, 4'd7, 4'd8);
    s1_nxt = cas(s1_nxt, 4'd0, 4'd1);
    s1_nxt = cas(s1_nxt, 4'd3, 4'd4);
    s1_nxt = cas(s1_nxt, 4'd6, 4'd7);
    s1_nxt = cas(s1_nxt, 4'd1, 4'd2);
    s1_nxt = cas(s1_nxt, 4'd4, 4'd5);
    s1_nxt = cas(s1_nxt, 4'd7, 4'd8);
  end

  always_comb begin
    s2_nxt = p1_r;
    s2_nxt = cas(s2_nxt, 4'd0, 4'd3);
    s2_nxt = cas(s2_nxt, 4'd5, 4'd8);
    s2_nxt = cas(s2_nxt, 4'd4, 4'd7);
    s2_nxt = cas(s2_nxt, 4'd3, 4'd6);
    s2_nxt = cas(s2_nxt, 4'd1, 4'd4);
    s2_nxt = cas(s2_nxt, 4'd2, 4'd5);
  end

  always_comb begin
    s3_nxt = p2_r;
    s3_nxt = cas(s3_nxt, 4'd4, 4'd7);
    s3_nxt = cas(s3_nxt, 4'd4, 4'd2);
    s3_nxt = cas(s3_nxt, 4'd6, 4'd4);
    s3_nxt = cas(s3_nxt, 4'd4, 4'd2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      p1_r <= s1_nxt;
      t1_r <= in_tag;
    end
    if (rdy2 && v1_r) begin
      p2_r <= s2_nxt;
      t2_r <= t1_r;
    end
    if (rdy3 && v2_r) begin
      med_r <= s3_nxt[4];
      t3_r  <= t2_r;
    end
  end

  assign out_valid = v3_r;
  assign out_med   = med_r;
  assign out_tag   = t3_r;

endmodule

`default_nettype wire

// File: design/median_filter_3x3_replicate.sv
// 3x3 median filter with replicated image borders.
// Input: one 8-bit pixel per transfer on in_t*, in raster order. Output: one
// median per transfer on out_t*, in raster order, carrying the median, its row
// and column, and tlast on the final result caused by one input pixel.
// Configuration: cfg_index 0 writes the image width, 1 the image height; any
// such write restarts the frame at pixel (0,0). Write only while the block is
// idle. cfg_ready is always high.
// Path: a result is registered through the input stage, the result sequencer and
// the median pipeline before it appears on out_tvalid.
// Throughput: one pixel per clock while the output does not stall. The last pixel
// of each row after the first yields two results and pixels of the last row up to
// four; the result sequencer issues one result per clock into the median pipeline
// while it is ready, so in_tready drops while the extra results are issued.
// Reset: width and height return to 256, the position to (0,0) and the window
// to zero. The line stores are not cleared; entries are only read after the
// current frame has written them.
// Stall: when out_tready is low the output register holds; the median pipeline,
// the sequencer and then in_tready back up behind it.
`default_nettype none

module median_filter_3x3_replicate import mf3_pkg::*; #(
  parameter int MAX_WIDTH = MF3_MAX_WIDTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [7:0]        in_tdata,   // [7:0] pixel_in
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic      [31:0]       out_tdata,  // [7:0] median_out, [19:8] out_row,
                                             // [27:20] out_col, [31:28] zero
  output logic                   out_tlast,  // last_of_run
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CIDX_W-1:0] cfg_index,
  input  wire logic [HCFG_W-1:0] cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int EW = (CW + 1 > WCFG_W) ? CW + 1 : WCFG_W;

  // Configuration
  logic [WCFG_W-1:0] width_r;
  logic [HCFG_W-1:0] height_r;
  logic              cfg_fire;
  logic [EW-1:0]     w_ext;
  logic [CW-1:0]     w_m1;
  logic [ROW_W-1:0]  h_m1;

  // Position of the next input
  logic [CW-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             in_fire;

  // Stage holding the accepted pixel while the line store is read
  logic             s1_valid_r;
  logic             s1_fire;
  pix_t             s1_pix_r;
  logic [CW-1:0]    s1_col_r;
  logic [ROW_W-1:0] s1_row_r;
  logic             s1_byp_r;
  logic [15:0]      s1_bypdata_r;
  logic [15:0]      ram_rd;
  logic [15:0]      line_q;
  logic [15:0]      line_wr;
  pix_t             prev_px, older_px;

  // Window
  col3_t            new_col;
  col3_t            win [3];

  // Result sequencer
  logic             exp_busy_r;
  logic             exp_bot_r, exp_right_r;
  logic             exp_has_bot_r, exp_has_left_r, exp_has_right_r;
  logic             exp_top_older_r, exp_bot_prev_r;
  logic [ROW_W-1:0] exp_row_r;
  logic [CW-1:0]    exp_col_r;
  logic             exp_issue, exp_last, exp_free;
  logic             more_col, more_row;
  logic             has_top, has_bot, has_left, has_right;
  logic [1:0]       rsel [3];
  logic [1:0]       csel [3];
  pix9_t            med_vals;
  res_tag_t         med_tag;
  logic [CW-1:0]    res_col;
  logic             med_in_ready;

  pix_t             med_out;
  res_tag_t         out_tag;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WCFG_W'(256);
      height_r <= HCFG_W'(256);
    end else if (cfg_fire) begin
      case (cfg_index)
        CFG_IDX_WIDTH:  width_r  <= cfg_data[WCFG_W-1:0];
        CFG_IDX_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign w_ext = EW'(width_r);

  always_comb begin
    if (w_ext == '0) begin
      w_m1 = '0;
    end else if (w_ext > EW'(MAX_WIDTH)) begin
      w_m1 = CW'(MAX_WIDTH - 1);
    end else begin
      w_m1 = CW'(w_ext - EW'(1));
    end
  end

  assign h_m1 = (height_r == '0) ? '0 : height_r - ROW_W'(1);

  // Input side
  assign in_tready = !s1_valid_r || s1_fire;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_fire) begin
      if (col_r == w_m1) begin
        col_nxt = '0;
        row_nxt = (row_r == h_m1) ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (cfg_fire && (cfg_index inside {CFG_IDX_WIDTH, CFG_IDX_HEIGHT})) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  // A write in the same cycle to the column being read is forwarded.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pix_r     <= in_tdata;
      s1_col_r     <= col_r;
      s1_row_r     <= row_r;
      s1_byp_r     <= s1_fire && (s1_col_r == col_r);
      s1_bypdata_r <= line_wr;
    end
  end

  // Line entry: [15:8] previous row, [7:0] the row before it.
  mf3_ram #(
    .WIDTH (16),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk     (clk),
    .wr_en   (s1_fire),
    .wr_addr (s1_col_r),
    .wr_data (line_wr),
    .rd_en   (in_fire),
    .rd_addr (col_r),
    .rd_data (ram_rd)
  );

  assign line_q   = s1_byp_r ? s1_bypdata_r : ram_rd;
  assign prev_px  = (s1_row_r >= ROW_W'(1)) ? line_q[15:8] : '0;
  assign older_px = (s1_row_r >= ROW_W'(2)) ? line_q[7:0] : '0;
  assign line_wr  = {s1_pix_r, prev_px};

  assign s1_fire = s1_valid_r && exp_free;

  // Window: three column cells shifting toward column 0.
  assign new_col[0] = older_px;
  assign new_col[1] = prev_px;
  assign new_col[2] = s1_pix_r;

  for (genvar k = 0; k < 3; k++) begin : g_cell
    if (k == 2) begin : g_head
      mf3_col_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (s1_fire),
        .fill     (1'b1),
        .new_col  (new_col),
        .next_col (new_col),
        .col_q    (win[k])
      );
    end else begin : g_body
      mf3_col_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (s1_fire),
        .fill     (s1_col_r == '0),
        .new_col  (new_col),
        .next_col (win[k+1]),
        .col_q    (win[k])
      );
    end
  end

  // Result sequencer: walks the top/bottom rows and left/right columns due.
  assign has_top   = s1_row_r >= ROW_W'(1);
  assign has_bot   = s1_row_r == h_m1;
  assign has_left  = s1_col_r != '0;
  assign has_right = s1_col_r == w_m1;

  assign more_col  = !exp_right_r && exp_has_right_r;
  assign more_row  = !exp_bot_r && exp_has_bot_r;
  assign exp_last  = !more_col && !more_row;
  assign exp_issue = exp_busy_r && med_in_ready;
  assign exp_free  = !exp_busy_r || (exp_issue && exp_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_busy_r <= 1'b0;
    end else if (s1_fire) begin
      exp_busy_r <= (has_top || has_bot) && (has_left || has_right);
    end else if (exp_issue && exp_last) begin
      exp_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      exp_bot_r       <= !has_top;
      exp_right_r     <= !has_left;
      exp_has_bot_r   <= has_bot;
      exp_has_left_r  <= has_left;
      exp_has_right_r <= has_right;
      exp_top_older_r <= s1_row_r >= ROW_W'(2);
      exp_bot_prev_r  <= has_top;
      exp_row_r       <= s1_row_r;
      exp_col_r       <= s1_col_r;
    end else if (exp_issue) begin
      if (more_col) begin
        exp_right_r <= 1'b1;
      end else if (more_row) begin
        exp_bot_r   <= 1'b1;
        exp_right_r <= !exp_has_left_r;
      end
    end
  end

  always_comb begin
    rsel[0] = exp_bot_r ? (exp_bot_prev_r ? 2'd1 : 2'd2) : (exp_top_older_r ? 2'd0 : 2'd1);
    rsel[1] = exp_bot_r ? 2'd2 : 2'd1;
    rsel[2] = 2'd2;
    csel[0] = exp_right_r ? 2'd1 : 2'd0;
    csel[1] = exp_right_r ? 2'd2 : 2'd1;
    csel[2] = 2'd2;
  end

  for (genvar i = 0; i < 3; i++) begin : g_row
    for (genvar j = 0; j < 3; j++) begin : g_col
      assign med_vals[i*3+j] = win[csel[j]][rsel[i]];
    end
  end

  assign res_col       = exp_right_r ? exp_col_r : exp_col_r - CW'(1);
  assign med_tag.row   = exp_bot_r ? exp_row_r : exp_row_r - ROW_W'(1);
  assign med_tag.col   = OCOL_W'(res_col);
  assign med_tag.last  = exp_last;

  mf3_median9 u_med (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (exp_busy_r),
    .in_ready  (med_in_ready),
    .in_pix    (med_vals),
    .in_tag    (med_tag),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_med   (med_out),
    .out_tag   (out_tag)
  );

  assign out_tdata = {4'b0000, out_tag.col, out_tag.row, med_out};
  assign out_tlast = out_tag.last;

endmodule

`default_nettype wire

// File: design/mf3_checker.sv
`default_nettype none

module mf3_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic        out_tlast
);

  // A stalled result holds until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // The cycle after reset shows no result.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result present right after reset");

  // The padding bits above the packed fields are zero.
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[31:28] == 4'h0)
    else $error("nonzero padding in result");

  // A row index never wraps below zero.
  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[19:8] != 12'hFFF)
    else $error("row index out of range");

endmodule

bind median_filter_3x3_replicate mf3_checker u_mf3_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire
